// ===== rtl/mf3_pkg.sv =====
// Shared constants, types and median functions of the 3x3 median filter.
`timescale 1ns / 1ps

package mf3_pkg;

    localparam int PIXEL_BITS   = 16;
    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_HEIGHT   = 4096;
    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int ROW_BITS     = $clog2(MAX_HEIGHT);
    localparam int WDIM_BITS    = COL_BITS + 1;
    localparam int HDIM_BITS    = ROW_BITS + 1;
    localparam int WIDTH_BITS   = 12;
    localparam int HEIGHT_BITS  = 13;
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int ADDR_BITS    = 3;
    localparam int DATA_BITS    = 32;
    localparam int OUT_DEPTH    = 8;
    localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
    localparam int OUT_LVL_BITS = OUT_PTR_BITS + 2;

    typedef enum logic {
        CMD_PUSH  = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_t;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    typedef logic [PIXEL_BITS-1:0] pix_t;
    typedef pix_t [8:0] pix9_t;
    typedef pix_t [5:0] pix6_t;
    typedef pix_t [3:0] pix4_t;
    typedef logic [COL_BITS-1:0] col_t;
    typedef logic [ROW_BITS-1:0] row_t;

    typedef struct packed {
        pix_t filtered_value;
        col_t out_column;
        row_t out_row;
        logic frame_last;
    } res_t;

    // Item held between the memory access and the median stage.
    typedef struct packed {
        logic push;
        logic drain;
        logic load;
        logic up_half;
        logic row_odd;
        logic emit_a;
        logic emit_b;
        logic top_ok;
        logic left_ok;
        logic d_first;
        logic d_last;
        col_t col_a;
        col_t col_b;
        row_t row_out;
        pix_t pixel;
    } s1_t;

    typedef struct packed {
        logic wr_a;
        logic wr_b;
        res_t res_a;
        res_t res_b;
    } wr_t;

    // Compare and swap: returns {larger, smaller}.
    function automatic logic [2*PIXEL_BITS-1:0] cs(input pix_t a, input pix_t b);
        return (a > b) ? {a, b} : {b, a};
    endfunction

    function automatic pix_t mean2(input pix_t a, input pix_t b);
        logic [PIXEL_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PIXEL_BITS:1];
    endfunction

    // Median of nine with the classic 19-exchange network.
    function automatic pix_t med9(input pix9_t v);
        pix9_t p;
        p = v;
        {p[2], p[1]} = cs(p[1], p[2]);
        {p[5], p[4]} = cs(p[4], p[5]);
        {p[8], p[7]} = cs(p[7], p[8]);
        {p[1], p[0]} = cs(p[0], p[1]);
        {p[4], p[3]} = cs(p[3], p[4]);
        {p[7], p[6]} = cs(p[6], p[7]);
        {p[2], p[1]} = cs(p[1], p[2]);
        {p[5], p[4]} = cs(p[4], p[5]);
        {p[8], p[7]} = cs(p[7], p[8]);
        {p[3], p[0]} = cs(p[0], p[3]);
        {p[8], p[5]} = cs(p[5], p[8]);
        {p[7], p[4]} = cs(p[4], p[7]);
        {p[6], p[3]} = cs(p[3], p[6]);
        {p[4], p[1]} = cs(p[1], p[4]);
        {p[5], p[2]} = cs(p[2], p[5]);
        {p[7], p[4]} = cs(p[4], p[7]);
        {p[2], p[4]} = cs(p[4], p[2]);
        {p[4], p[6]} = cs(p[6], p[4]);
        {p[2], p[4]} = cs(p[4], p[2]);
        return p[4];
    endfunction

    // Median of six: odd-even transposition sort, mean of the middle pair.
    function automatic pix_t med6(input pix6_t v);
        pix6_t p;
        int idx;
        p = v;
        for (int pass = 0; pass < 6; pass++) begin
            for (int i = 0; i < 3; i++) begin
                idx = 2 * i + (pass % 2);
                if (idx < 5) begin
                    {p[idx+1], p[idx]} = cs(p[idx], p[idx+1]);
                end
            end
        end
        return mean2(p[2], p[3]);
    endfunction

    function automatic pix_t med4(input pix4_t v);
        pix4_t p;
        p = v;
        {p[1], p[0]} = cs(p[0], p[1]);
        {p[3], p[2]} = cs(p[2], p[3]);
        {p[2], p[0]} = cs(p[0], p[2]);
        {p[3], p[1]} = cs(p[1], p[3]);
        {p[2], p[1]} = cs(p[1], p[2]);
        return mean2(p[1], p[2]);
    endfunction

endpackage

// ===== rtl/mf3_in_if.sv =====
// Input channel: command and pixel word with valid/ready.
`timescale 1ns / 1ps

interface mf3_in_if;
    import mf3_pkg::*;

    logic valid;
    logic ready;
    logic command;
    pix_t pixel_value;

    modport source (output valid, output command, output pixel_value, input ready);
    modport sink (input valid, input command, input pixel_value, output ready);
endinterface

// ===== rtl/mf3_out_if.sv =====
// Output channel: filtered pixel word with position and valid/ready.
`timescale 1ns / 1ps

interface mf3_out_if;
    import mf3_pkg::*;

    logic valid;
    logic ready;
    pix_t filtered_value;
    col_t out_column;
    row_t out_row;
    logic frame_last;

    modport source (output valid, output filtered_value, output out_column,
                    output out_row, output frame_last, input ready);
    modport sink (input valid, input filtered_value, input out_column,
                  input out_row, input frame_last, output ready);
endinterface

// ===== rtl/median_filter_3x3_shrinking_edges.sv =====
// Top level of the streaming 3x3 median filter with clipped borders.
`timescale 1ns / 1ps

// Streaming 3x3 median filter for one grey frame in raster order. Each input
// word either pushes the next pixel or, once the whole frame has been pushed,
// drains one pixel of the bottom row; a drain before the frame is complete
// and a push while the bottom row is pending are accepted and dropped. Every
// result is the median of the neighbourhood clipped to the image (nine, six
// or four pixels; for an even count the floor of the mean of the two middle
// values). The result for row r-1, column c-1 comes out after pixel (r, c)
// is pushed, so results lag one line, and the end of each line also gives
// the last column of the line above. After the frame, image_width drain
// words flush the bottom row, the last one flagged with frame_last. One word
// is taken every clock unless input stalls: the pixel is written to and two
// lines are read from the line store at the accept edge, the window shifts
// and the medians are formed in the next cycle and enter an eight-deep
// result queue. Input stalls only while that queue lacks room for the
// results of the incoming word and of the word in the median stage: fewer
// than two free places with that stage empty, fewer than four with it busy.
// A write to image_width (byte address 0) or image_height (address 4) restarts
// the frame; values out of range are clamped to 2..2048 and 2..4096.
module median_filter_3x3_shrinking_edges (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mf3_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [mf3_pkg::DATA_BITS-1:0]   pwdata,
    output logic [mf3_pkg::DATA_BITS-1:0]   prdata,
    output logic                            pready,
    mf3_in_if.sink                          in_word,
    mf3_out_if.source                       out_word
);
    import mf3_pkg::*;

    // Configuration registers and the dimensions clamped into range.
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [WDIM_BITS-1:0]   w;
    logic [HDIM_BITS-1:0]   h;
    logic                   cfg_write;
    reg_idx_t               cfg_idx;

    // Raster position of the next push and the bottom-row drain position.
    col_t in_col_reg, in_col_next;
    row_t in_row_reg, in_row_next;
    col_t drain_col_reg, drain_col_next;
    logic frame_done_reg, frame_done_next;

    s1_t  s1_reg, s1_next;
    wr_t  wr;
    logic [OUT_LVL_BITS-1:0] level;

    logic accept, push_eff, drain_eff, last_col, last_row, d_last;
    col_t b_addr;
    pix_t a_half0, a_half1, b_half0, b_half1;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_BITS-1]);

    always_comb
    begin
        if (cfg_idx == REG_IMAGE_HEIGHT)
        begin
            prdata = DATA_BITS'(height_reg);
        end
        else
        begin
            prdata = DATA_BITS'(width_reg);
        end
    end

    always_comb
    begin
        if (width_reg < WIDTH_BITS'(2))
        begin
            w = WDIM_BITS'(2);
        end
        else if (width_reg > WIDTH_BITS'(MAX_WIDTH))
        begin
            w = WDIM_BITS'(MAX_WIDTH);
        end
        else
        begin
            w = WDIM_BITS'(width_reg);
        end

        if (height_reg < HEIGHT_BITS'(2))
        begin
            h = HDIM_BITS'(2);
        end
        else if (height_reg > HEIGHT_BITS'(MAX_HEIGHT))
        begin
            h = HDIM_BITS'(MAX_HEIGHT);
        end
        else
        begin
            h = HDIM_BITS'(height_reg);
        end
    end

    // The queue must have room for this word's results and for those of the
    // word already in the median stage.
    always_comb
    begin
        in_word.ready = (level + ((s1_reg.push || s1_reg.drain) ? OUT_LVL_BITS'(2)
                                                                : OUT_LVL_BITS'(0)))
                        <= OUT_LVL_BITS'(OUT_DEPTH - 2);
    end

    always_comb
    begin
        accept    = in_word.valid && in_word.ready;
        push_eff  = accept && (in_word.command == CMD_PUSH) && !frame_done_reg;
        drain_eff = accept && (in_word.command == CMD_DRAIN) && frame_done_reg;
        last_col  = ({1'b0, in_col_reg} + WDIM_BITS'(1)) == w;
        last_row  = ({1'b0, in_row_reg} + HDIM_BITS'(1)) == h;
        d_last    = ({1'b0, drain_col_reg} + WDIM_BITS'(1)) == w;

        // Second read port: column 0 of the last two lines on the final push,
        // then one column ahead of each drain, held at the last column.
        if (!frame_done_reg)
        begin
            b_addr = '0;
        end
        else if (d_last)
        begin
            b_addr = drain_col_reg;
        end
        else
        begin
            b_addr = drain_col_reg + COL_BITS'(1);
        end

        in_col_next     = in_col_reg;
        in_row_next     = in_row_reg;
        drain_col_next  = drain_col_reg;
        frame_done_next = frame_done_reg;
        if (push_eff)
        begin
            if (last_col)
            begin
                in_col_next = '0;
                if (last_row)
                begin
                    in_row_next     = '0;
                    frame_done_next = 1'b1;
                    drain_col_next  = '0;
                end
                else
                begin
                    in_row_next = in_row_reg + ROW_BITS'(1);
                end
            end
            else
            begin
                in_col_next = in_col_reg + COL_BITS'(1);
            end
        end
        else if (drain_eff)
        begin
            if (d_last)
            begin
                drain_col_next  = '0;
                frame_done_next = 1'b0;
            end
            else
            begin
                drain_col_next = drain_col_reg + COL_BITS'(1);
            end
        end

        s1_next.push    = push_eff;
        s1_next.drain   = drain_eff;
        s1_next.load    = push_eff && last_col && last_row;
        s1_next.up_half = h[0];
        s1_next.row_odd = in_row_reg[0];
        s1_next.emit_a  = (in_row_reg != '0) && (in_col_reg != '0);
        s1_next.emit_b  = (in_row_reg != '0) && last_col;
        s1_next.top_ok  = in_row_reg > ROW_BITS'(1);
        s1_next.left_ok = in_col_reg > COL_BITS'(1);
        s1_next.d_first = (drain_col_reg == '0);
        s1_next.d_last  = d_last;
        s1_next.col_a   = frame_done_reg ? drain_col_reg : in_col_reg - COL_BITS'(1);
        s1_next.col_b   = in_col_reg;
        s1_next.row_out = frame_done_reg ? ROW_BITS'(h - HDIM_BITS'(1))
                                         : in_row_reg - ROW_BITS'(1);
        s1_next.pixel   = in_word.pixel_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= WIDTH_BITS'(WIDTH_RESET);
            height_reg     <= HEIGHT_BITS'(HEIGHT_RESET);
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            drain_col_reg  <= '0;
            frame_done_reg <= 1'b0;
            s1_reg         <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_idx == REG_IMAGE_HEIGHT)
            begin
                height_reg <= pwdata[HEIGHT_BITS-1:0];
            end
            else
            begin
                width_reg <= pwdata[WIDTH_BITS-1:0];
            end
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            drain_col_reg  <= '0;
            frame_done_reg <= 1'b0;
            s1_reg         <= '0;
        end
        else
        begin
            in_col_reg     <= in_col_next;
            in_row_reg     <= in_row_next;
            drain_col_reg  <= drain_col_next;
            frame_done_reg <= frame_done_next;
            s1_reg         <= s1_next;
        end
    end

    // Line store: one half per line parity; a push overwrites the older line.
    mf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line0 (
        .clk     (clk),
        .we      (push_eff && !in_row_reg[0]),
        .waddr   (in_col_reg),
        .wdata   (in_word.pixel_value),
        .ra_addr (in_col_reg),
        .ra_data (a_half0),
        .rb_addr (b_addr),
        .rb_data (b_half0)
    );

    mf3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line1 (
        .clk     (clk),
        .we      (push_eff && in_row_reg[0]),
        .waddr   (in_col_reg),
        .wdata   (in_word.pixel_value),
        .ra_addr (in_col_reg),
        .ra_data (a_half1),
        .rb_addr (b_addr),
        .rb_data (b_half1)
    );

    mf3_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_write),
        .s1      (s1_reg),
        .a_half0 (a_half0),
        .a_half1 (a_half1),
        .b_half0 (b_half0),
        .b_half1 (b_half1),
        .wr      (wr)
    );

    mf3_out_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .level    (level),
        .out_word (out_word)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        level <= OUT_LVL_BITS'(OUT_DEPTH))
        else $error("result queue overflow");

    a_done_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done_reg |-> (in_col_reg == '0) && (in_row_reg == '0))
        else $error("pending bottom row with push position not at origin");

    a_drain_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done_reg |-> ({1'b0, drain_col_reg} < w))
        else $error("drain column beyond line");

    a_drain_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        s1_reg.drain |-> (wr.wr_a && !wr.wr_b))
        else $error("drain did not give exactly one word");

    a_room_kept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (level <= OUT_LVL_BITS'(OUT_DEPTH - 2)))
        else $error("accepted word without room reserved");
`endif
endmodule

// ===== rtl/mf3_ram.sv =====
// Generic RAM: one write port, two registered read ports, read-first.
`timescale 1ns / 1ps

module mf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] ra_addr,
    output logic [WIDTH-1:0]         ra_data,
    input  logic [$clog2(DEPTH)-1:0] rb_addr,
    output logic [WIDTH-1:0]         rb_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end
endmodule

// ===== rtl/mf3_window.sv =====
// Window registers and median selection for one stage-one item.
`timescale 1ns / 1ps

module mf3_window (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            restart,
    input  mf3_pkg::s1_t    s1,
    input  mf3_pkg::pix_t   a_half0,
    input  mf3_pkg::pix_t   a_half1,
    input  mf3_pkg::pix_t   b_half0,
    input  mf3_pkg::pix_t   b_half1,
    output mf3_pkg::wr_t    wr
);
    import mf3_pkg::*;

    pix9_t win_reg;
    pix9_t win_next;
    pix6_t dwin_reg;
    pix6_t dwin_next;
    pix6_t v6r, v6c;
    pix4_t v4, vd4f, vd4l;
    pix_t  m9, m6r, m6c, m4, md6, md4f, md4l;
    pix_t  top, mid, up, lo, val_a, val_b, val_d;

    always_comb
    begin
        top = s1.row_odd ? a_half1 : a_half0;
        mid = s1.row_odd ? a_half0 : a_half1;
        up  = s1.up_half ? b_half1 : b_half0;
        lo  = s1.up_half ? b_half0 : b_half1;

        for (int k = 0; k < 3; k++)
        begin
            win_next[k*3+0] = win_reg[k*3+1];
            win_next[k*3+1] = win_reg[k*3+2];
        end
        win_next[2] = top;
        win_next[5] = mid;
        win_next[8] = s1.pixel;

        for (int k = 0; k < 2; k++)
        begin
            dwin_next[k*3+0] = dwin_reg[k*3+1];
            dwin_next[k*3+1] = dwin_reg[k*3+2];
        end
        dwin_next[2] = up;
        dwin_next[5] = lo;

        for (int i = 0; i < 6; i++)
        begin
            v6r[i] = win_next[i+3];
        end
        v6c[0] = win_next[1];
        v6c[1] = win_next[2];
        v6c[2] = win_next[4];
        v6c[3] = win_next[5];
        v6c[4] = win_next[7];
        v6c[5] = win_next[8];
        v4[0] = win_next[4];
        v4[1] = win_next[5];
        v4[2] = win_next[7];
        v4[3] = win_next[8];
        vd4f[0] = dwin_next[1];
        vd4f[1] = dwin_next[2];
        vd4f[2] = dwin_next[4];
        vd4f[3] = dwin_next[5];
        vd4l[0] = dwin_next[0];
        vd4l[1] = dwin_next[1];
        vd4l[2] = dwin_next[3];
        vd4l[3] = dwin_next[4];

        m9   = med9(win_next);
        m6r  = med6(v6r);
        m6c  = med6(v6c);
        m4   = med4(v4);
        md6  = med6(dwin_next);
        md4f = med4(vd4f);
        md4l = med4(vd4l);

        if (s1.top_ok)
        begin
            val_a = s1.left_ok ? m9 : m6c;
            val_b = m6c;
        end
        else
        begin
            val_a = s1.left_ok ? m6r : m4;
            val_b = m4;
        end

        if (s1.d_first)
        begin
            val_d = md4f;
        end
        else if (s1.d_last)
        begin
            val_d = md4l;
        end
        else
        begin
            val_d = md6;
        end

        wr.wr_a = (s1.push && s1.emit_a) || s1.drain;
        wr.wr_b = s1.push && s1.emit_b;
        wr.res_a.filtered_value = s1.drain ? val_d : val_a;
        wr.res_a.out_column     = s1.col_a;
        wr.res_a.out_row        = s1.row_out;
        wr.res_a.frame_last     = s1.drain && s1.d_last;
        wr.res_b.filtered_value = val_b;
        wr.res_b.out_column     = s1.col_b;
        wr.res_b.out_row        = s1.row_out;
        wr.res_b.frame_last     = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            dwin_reg <= '0;
        end
        else if (restart)
        begin
            win_reg  <= '0;
            dwin_reg <= '0;
        end
        else
        begin
            if (s1.push)
            begin
                win_reg <= win_next;
            end
            if (s1.drain || s1.load)
            begin
                dwin_reg <= dwin_next;
            end
        end
    end
endmodule

// ===== rtl/mf3_out_fifo.sv =====
// Result queue taking up to two words a cycle and giving one while the receiver is ready.
`timescale 1ns / 1ps

module mf3_out_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mf3_pkg::wr_t                   wr,
    output logic [mf3_pkg::OUT_LVL_BITS-1:0] level,
    mf3_out_if.source                      out_word
);
    import mf3_pkg::*;

    res_t entry_reg [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUT_LVL_BITS-1:0] count_reg, count_next;
    logic [OUT_PTR_BITS-1:0] wr_ptr_plus1;
    logic pop;
    logic [1:0] n_wr;

    always_comb
    begin
        pop          = out_word.valid && out_word.ready;
        n_wr         = {1'b0, wr.wr_a} + {1'b0, wr.wr_b};
        wr_ptr_plus1 = wr_ptr_reg + OUT_PTR_BITS'(1);
        wr_ptr_next  = wr_ptr_reg + OUT_PTR_BITS'(n_wr);
        rd_ptr_next  = rd_ptr_reg + OUT_PTR_BITS'(pop);
        count_next   = count_reg + OUT_LVL_BITS'(n_wr) - OUT_LVL_BITS'(pop);
    end

    assign level                   = count_reg;
    assign out_word.valid          = (count_reg != '0);
    assign out_word.filtered_value = entry_reg[rd_ptr_reg].filtered_value;
    assign out_word.out_column     = entry_reg[rd_ptr_reg].out_column;
    assign out_word.out_row        = entry_reg[rd_ptr_reg].out_row;
    assign out_word.frame_last     = entry_reg[rd_ptr_reg].frame_last;

    always_ff @(posedge clk)
    begin
        if (wr.wr_a)
        begin
            entry_reg[wr_ptr_reg] <= wr.res_a;
        end
        if (wr.wr_b)
        begin
            entry_reg[wr_ptr_plus1] <= wr.res_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

// ===== verif/mf3_checker.sv =====
// Checker that mirrors the 3x3 median filter and compares every output word.
`timescale 1ns / 1ps

module mf3_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [mf3_pkg::ADDR_BITS-1:0] paddr,
    input  logic [mf3_pkg::DATA_BITS-1:0] pwdata,
    mf3_in_if                             in_mon,
    mf3_out_if                            out_mon,
    output int                            fail_count,
    output int                            pending_count,
    output int                            words_seen,
    output int                            results_seen
);
    import mf3_pkg::*;

    pix_t                 line_mem [0:2*MAX_WIDTH-1];
    pix_t                 win [9];
    int unsigned          col_next;
    int unsigned          row_next;
    int unsigned          drain_col;
    bit                   bottom_pending;
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    res_t                 filtered_q [$];

    initial
    begin
        for (int i = 0; i < 2 * MAX_WIDTH; i++)
        begin
            line_mem[i] = '0;
        end
        fail_count    = 0;
        pending_count = 0;
        words_seen    = 0;
        results_seen  = 0;
    end

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 2)
        begin
            return 2;
        end
        return (v > hi) ? hi : v;
    endfunction

    // Median of the window cells in rows rlo..rhi and columns clo..chi.
    function automatic pix_t clip_median(input pix_t g [9], input int rlo, input int rhi,
                                         input int clo, input int chi);
        int unsigned vals [9];
        int unsigned x;
        int          n;
        int          k;
        n = 0;
        for (int r = rlo; r <= rhi; r++)
        begin
            for (int c = clo; c <= chi; c++)
            begin
                x = 32'(g[r * 3 + c]);
                k = n;
                n++;
                while (k > 0 && vals[k - 1] > x)
                begin
                    vals[k] = vals[k - 1];
                    k--;
                end
                vals[k] = x;
            end
        end
        if (n % 2 == 1)
        begin
            return pix_t'(vals[n / 2]);
        end
        return pix_t'((vals[n / 2 - 1] + vals[n / 2]) >> 1);
    endfunction

    function automatic res_t make_res(input pix_t v, input int unsigned c, input int unsigned r,
                                      input bit last);
        res_t t;
        t.filtered_value = v;
        t.out_column     = col_t'(c);
        t.out_row        = row_t'(r);
        t.frame_last     = last;
        return t;
    endfunction

    task automatic restart_frame();
        for (int i = 0; i < 9; i++)
        begin
            win[i] = '0;
        end
        col_next       = 0;
        row_next       = 0;
        drain_col      = 0;
        bottom_pending = 0;
    endtask

    task automatic filter_word(input logic cmd, input pix_t pix);
        int unsigned w;
        int unsigned h;
        int unsigned d;
        int unsigned up;
        int unsigned lo;
        int unsigned r;
        int unsigned c;
        int unsigned older;
        int unsigned prev;
        int          rlo;
        int          x;
        pix_t        g [9];
        pix_t        top_px;
        pix_t        mid_px;
        w = clamp_dim(32'(width_reg), MAX_WIDTH);
        h = clamp_dim(32'(height_reg), MAX_HEIGHT);
        if (cmd == CMD_DRAIN)
        begin
            if (!bottom_pending)
            begin
                return;
            end
            d  = (drain_col >= w) ? w - 1 : drain_col;
            up = ((h - 2) % 2) * MAX_WIDTH;
            lo = ((h - 1) % 2) * MAX_WIDTH;
            for (int i = 0; i < 9; i++)
            begin
                g[i] = '0;
            end
            for (int k = 0; k < 3; k++)
            begin
                x = int'(d) - 1 + k;
                if (x >= 0 && x < int'(w))
                begin
                    g[k]     = line_mem[up + x];
                    g[3 + k] = line_mem[lo + x];
                end
            end
            filtered_q.push_back(make_res(clip_median(g, 0, 1, (d == 0) ? 1 : 0,
                                                      (d + 1 < w) ? 2 : 1),
                                          d, h - 1, d == w - 1));
            d++;
            if (d >= w)
            begin
                d              = 0;
                bottom_pending = 0;
            end
            drain_col = d;
            return;
        end
        // A pushed pixel while the bottom row waits for drains is dropped.
        if (bottom_pending)
        begin
            return;
        end
        r      = (row_next < h) ? row_next : h - 1;
        c      = (col_next < w) ? col_next : w - 1;
        older  = (r % 2) * MAX_WIDTH + c;
        prev   = ((r + 1) % 2) * MAX_WIDTH + c;
        top_px = line_mem[older];
        mid_px = line_mem[prev];
        line_mem[older] = pix;
        for (int k = 0; k < 3; k++)
        begin
            win[k * 3]     = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = top_px;
        win[5] = mid_px;
        win[8] = pix;
        if (r >= 1)
        begin
            rlo = (r >= 2) ? 0 : 1;
            if (c >= 1)
            begin
                filtered_q.push_back(make_res(clip_median(win, rlo, 2, (c >= 2) ? 0 : 1, 2),
                                              c - 1, r - 1, 0));
            end
            if (c == w - 1)
            begin
                filtered_q.push_back(make_res(clip_median(win, rlo, 2, 1, 2), w - 1, r - 1, 0));
            end
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
            begin
                r              = 0;
                bottom_pending = 1;
                drain_col      = 0;
            end
        end
        col_next = c;
        row_next = r;
    endtask

    task automatic check_result();
        res_t want;
        results_seen++;
        if (filtered_q.size() == 0)
        begin
            $error("unexpected output word: value %0d column %0d row %0d",
                   out_mon.filtered_value, out_mon.out_column, out_mon.out_row);
            fail_count++;
            return;
        end
        want = filtered_q.pop_front();
        if (out_mon.filtered_value !== want.filtered_value)
        begin
            $error("filtered_value: expected %0d, got %0d", want.filtered_value,
                   out_mon.filtered_value);
            fail_count++;
        end
        if (out_mon.out_column !== want.out_column)
        begin
            $error("out_column: expected %0d, got %0d", want.out_column, out_mon.out_column);
            fail_count++;
        end
        if (out_mon.out_row !== want.out_row)
        begin
            $error("out_row: expected %0d, got %0d", want.out_row, out_mon.out_row);
            fail_count++;
        end
        if (out_mon.frame_last !== want.frame_last)
        begin
            $error("frame_last: expected %0d, got %0d", want.frame_last, out_mon.frame_last);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_BITS'(WIDTH_RESET);
            height_reg <= HEIGHT_BITS'(HEIGHT_RESET);
            restart_frame();
            filtered_q.delete();
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                check_result();
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[ADDR_BITS-1:2] == REG_IMAGE_WIDTH)
                begin
                    width_reg <= pwdata[WIDTH_BITS-1:0];
                    restart_frame();
                end
                else if (paddr[ADDR_BITS-1:2] == REG_IMAGE_HEIGHT)
                begin
                    height_reg <= pwdata[HEIGHT_BITS-1:0];
                    restart_frame();
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                words_seen++;
                filter_word(in_mon.command, in_mon.pixel_value);
            end
            pending_count <= filtered_q.size();
        end
    end

endmodule

// ===== verif/tb_median_filter_3x3_shrinking_edges.sv =====
// Stimulus, clocking and verdict for the 3x3 median filter testbench.
`timescale 1ns / 1ps

module tb_median_filter_3x3_shrinking_edges;
    import mf3_pkg::*;

    localparam int IDLE_LIMIT  = 5000;
    localparam int SETTLE_WAIT = 12;
    localparam int RANDOM_WORDS = 400;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    int fail_count;
    int pending_count;
    int words_seen;
    int results_seen;

    // Knobs shared between the stimulus flow and the receiver.
    bit tx_burst;
    bit rx_burst;
    bit hold_req;
    int settings_done;
    int frames_done;
    int idle_cycles;

    mf3_in_if  in_word ();
    mf3_out_if out_word ();

    median_filter_3x3_shrinking_edges u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_word  (in_word),
        .out_word (out_word)
    );

    mf3_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .in_mon        (in_word),
        .out_mon       (out_word),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .words_seen    (words_seen),
        .results_seen  (results_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // The watchdog counts cycles in which no word moves on any port. Any
    // correct run keeps at least one of the channels busy well inside the
    // limit, even through the long receiver hold-off.
    always @(posedge clk)
    begin
        if ((in_word.valid && in_word.ready) || (out_word.valid && out_word.ready) ||
            (psel && penable))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: draws a stall before each result word. When asked it holds
    // off for a long stretch so the result queue fills and the input stalls.
    initial
    begin : receiver
        int n;
        out_word.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = rx_burst ? 0 : $urandom_range(0, 14);
            if (hold_req)
            begin
                n        = 300;
                hold_req = 0;
            end
            if (n > 0)
            begin
                out_word.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_word.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!(out_word.valid && out_word.ready));
        end
    end

    // Sends one word, after a random gap unless the sender is bursting.
    task automatic send_word(input cmd_t cmd, input pix_t pix);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_word.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_word.valid       <= 1'b1;
        in_word.command     <= cmd;
        in_word.pixel_value <= pix;
        do
        begin
            @(posedge clk);
        end
        while (!in_word.ready);
    endtask

    task automatic stop_sending();
        in_word.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every predicted word has come out. Pushes of the first line
    // produce no word, so a further settling wait lets the pipeline empty as well.
    task automatic wait_drained();
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    // APB write: setup cycle, then the access cycle that completes on pready.
    task automatic reg_write(input reg_idx_t idx, input int unsigned value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(4 * int'(idx));
        pwdata  <= DATA_BITS'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        settings_done++;
    endtask

    // Pixel values mix full range, the two rails and narrow bands next to
    // each rail that make many ties inside a window.
    function automatic pix_t rand_pixel();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
        begin
            return pix_t'($urandom);
        end
        else if (sel < 7)
        begin
            return sel[0] ? '1 : '0;
        end
        return pix_t'($urandom_range(0, 7) + (sel == 9 ? 65528 : 0));
    endfunction

    // One frame of pushes followed by the drains of the bottom row, with a
    // few stray words mixed in. A nonzero cut below the frame size stops the frame early.
    task automatic run_frame(input int w, input int h, input int cut);
        int total;
        total = (cut > 0 && cut < w * h) ? cut : w * h;
        for (int i = 0; i < total; i++)
        begin
            if ($urandom_range(0, 99) < 4)
            begin
                send_word(CMD_DRAIN, rand_pixel());
            end
            send_word(CMD_PUSH, rand_pixel());
        end
        if (total < w * h)
        begin
            return;
        end
        for (int i = 0; i < w; i++)
        begin
            if ($urandom_range(0, 99) < 4)
            begin
                send_word(CMD_PUSH, rand_pixel());
            end
            send_word(CMD_DRAIN, rand_pixel());
        end
        frames_done++;
    endtask

    initial
    begin : stimulus
        int   w;
        int   h;
        int   phase;
        int   frames;
        pix_t corner_px [9];
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        in_word.valid       = 1'b0;
        in_word.command     = CMD_PUSH;
        in_word.pixel_value = '0;
        tx_burst            = 0;
        rx_burst            = 0;
        hold_req            = 0;
        settings_done       = 0;
        frames_done         = 0;
        idle_cycles         = 0;
        rst_n               = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a 3x3 frame gives one interior pixel, edges and corners.
        // Rails and neighbouring codes stress the mean of the middle pair.
        corner_px = '{16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h0000,
                      16'h0001, 16'hFFFE, 16'h7FFF, 16'hFFFF};
        reg_write(REG_IMAGE_WIDTH, 3);
        reg_write(REG_IMAGE_HEIGHT, 3);
        // A drain with nothing pending is dropped.
        send_word(CMD_DRAIN, 16'hFFFF);
        for (int i = 0; i < 9; i++)
        begin
            send_word(CMD_PUSH, corner_px[i]);
        end
        // A push while the bottom row is pending is dropped.
        send_word(CMD_PUSH, 16'h1234);
        for (int i = 0; i < 3; i++)
        begin
            send_word(CMD_DRAIN, 16'h0000);
        end
        send_word(CMD_DRAIN, 16'h0000);
        stop_sending();

        // Values below the legal range clamp to two: a frame of corners only.
        reg_write(REG_IMAGE_WIDTH, 0);
        reg_write(REG_IMAGE_HEIGHT, 1);
        send_word(CMD_PUSH, 16'hFFFF);
        send_word(CMD_PUSH, 16'h0000);
        send_word(CMD_PUSH, 16'h0001);
        send_word(CMD_PUSH, 16'hFFFF);
        send_word(CMD_DRAIN, 16'h0000);
        send_word(CMD_DRAIN, 16'h0000);
        stop_sending();

        // Random part: small frames under many settings.
        phase = 0;
        w     = 2;
        h     = 2;
        while (words_seen < RANDOM_WORDS)
        begin
            if (phase == 0 || $urandom_range(0, 2) != 0)
            begin
                w = $urandom_range(2, 10);
                reg_write(REG_IMAGE_WIDTH, w);
            end
            if (phase == 0 || $urandom_range(0, 2) != 0)
            begin
                h = $urandom_range(2, 6);
                reg_write(REG_IMAGE_HEIGHT, h);
            end
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            if (phase == 2)
            begin
                // The receiver stops while words keep pouring in.
                tx_burst = 1;
                hold_req = 1;
            end
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                if (phase == 3 && f == 0)
                begin
                    // Sender pauses mid-frame until every result is out.
                    run_frame(w, h, (w * h) / 2);
                    stop_sending();
                    while (pending_count != 0)
                    begin
                        @(posedge clk);
                    end
                    run_frame(w, h, 0);
                end
                else
                begin
                    run_frame(w, h, ($urandom_range(0, 9) == 0) ? $urandom_range(1, w * h) : 0);
                end
            end
            stop_sending();
            phase++;
        end

        // Widest line: 4095 clamps to the largest width. The first line and
        // the start of the second show where the line wraps.
        tx_burst = 0;
        rx_burst = 0;
        reg_write(REG_IMAGE_WIDTH, 4095);
        reg_write(REG_IMAGE_HEIGHT, 2);
        run_frame(MAX_WIDTH, 2, MAX_WIDTH + 4);
        stop_sending();

        wait_drained();
        repeat (20) @(posedge clk);
        $display("covered %0d register writes, %0d complete frames, %0d input words",
                 settings_done, frames_done, words_seen);
        $display("checked %0d output words, including clamped dimensions and the widest line",
                 results_seen);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
